/* src/dsam_pkg.sv */
// Shared types, constants and helpers for the damper slew air mixer.
// No dependencies; used by every module of the block.
package dsam_pkg;

  localparam int FRAC_BITS   = 15;
  localparam int POS_W       = 16;
  localparam int VAL_W       = 16;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 112;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] ONE = POS_W'(1 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OA_LEAK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RA_LEAK    = 3'd5;

  typedef struct packed {
    logic        [POS_W-1:0] pos;
    logic        [POS_W-1:0] oa_cmd;
    logic        [POS_W-1:0] oa_act;
    logic        [POS_W-1:0] ra_act;
    logic signed [VAL_W-1:0] t_out;
    logic        [VAL_W-1:0] w_out;
    logic signed [VAL_W-1:0] t_ret;
    logic        [VAL_W-1:0] w_ret;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_rd_t;

  function automatic logic [POS_W-1:0] cap_one(input logic [POS_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

/* src/dsam_front.sv */
// Front end: configuration registers, actuator slew, opening and leak logic.
// Depends on dsam_pkg; pushes classified transactions into dsam_fifo.
module dsam_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsam_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dsam_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                q_full,
  output dsam_pkg::q_wr_t                     q_wr
);

  logic [dsam_pkg::POS_W-1:0] step_r, step_nxt;
  logic [dsam_pkg::POS_W-1:0] min_r, min_nxt;
  logic [dsam_pkg::CFG_W-1:0] stuck_r, stuck_nxt;
  logic                       rev_r, rev_nxt;
  logic [dsam_pkg::CFG_W-1:0] oleak_r, oleak_nxt;
  logic [dsam_pkg::CFG_W-1:0] rleak_r, rleak_nxt;
  logic [dsam_pkg::POS_W-1:0] damper_r, damper_nxt;

  logic                       accept;
  logic [dsam_pkg::POS_W-1:0] cmd, pos, dn, eff, lo, oa_act, ra_cmd, ra_act, oleak, rleak;
  logic [dsam_pkg::POS_W:0]   up;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tdata[15:0];

  always_comb begin
    step_nxt  = step_r;
    min_nxt   = min_r;
    stuck_nxt = stuck_r;
    rev_nxt   = rev_r;
    oleak_nxt = oleak_r;
    rleak_nxt = rleak_r;
    if (cfg_we) begin
      case (cfg_index)
        dsam_pkg::REG_STEP:    step_nxt  = cfg_wdata[15:0];
        dsam_pkg::REG_MIN_OA:  min_nxt   = cfg_wdata[15:0];
        dsam_pkg::REG_STUCK:   stuck_nxt = cfg_wdata;
        dsam_pkg::REG_REVERSE: rev_nxt   = cfg_wdata[0];
        dsam_pkg::REG_OA_LEAK: oleak_nxt = cfg_wdata;
        dsam_pkg::REG_RA_LEAK: rleak_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    up = {1'b0, damper_r} + {1'b0, step_r};
    dn = (damper_r > step_r) ? (damper_r - step_r) : '0;
    if (damper_r < cmd) begin
      pos = (up < {1'b0, cmd}) ? up[15:0] : cmd;
    end else if (damper_r > cmd) begin
      pos = (dn > cmd) ? dn : cmd;
    end else begin
      pos = cmd;
    end

    eff = dsam_pkg::cap_one(pos);
    lo  = dsam_pkg::cap_one(min_r);
    if (eff < lo) begin
      eff = lo;
    end
    if (!stuck_r[16]) begin
      eff = dsam_pkg::cap_one(stuck_r[15:0]);
    end
    if (rev_r) begin
      eff = dsam_pkg::ONE - eff;
    end

    ra_cmd = dsam_pkg::ONE - eff;
    oleak  = dsam_pkg::cap_one(oleak_r[15:0]);
    rleak  = dsam_pkg::cap_one(rleak_r[15:0]);
    oa_act = (!oleak_r[16] && oleak > eff) ? oleak : eff;
    ra_act = (!rleak_r[16] && rleak > ra_cmd) ? rleak : ra_cmd;

    damper_nxt = accept ? pos : damper_r;
  end

  always_comb begin
    q_wr.push        = accept;
    q_wr.item.pos    = pos;
    q_wr.item.oa_cmd = eff;
    q_wr.item.oa_act = oa_act;
    q_wr.item.ra_act = ra_act;
    q_wr.item.t_out  = in_tdata[31:16];
    q_wr.item.w_out  = in_tdata[47:32];
    q_wr.item.t_ret  = in_tdata[63:48];
    q_wr.item.w_ret  = in_tdata[79:64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= dsam_pkg::ONE;
      min_r    <= '0;
      stuck_r  <= '1;
      rev_r    <= 1'b0;
      oleak_r  <= '1;
      rleak_r  <= '1;
      damper_r <= '0;
    end else begin
      step_r   <= step_nxt;
      min_r    <= min_nxt;
      stuck_r  <= stuck_nxt;
      rev_r    <= rev_nxt;
      oleak_r  <= oleak_nxt;
      rleak_r  <= rleak_nxt;
      damper_r <= damper_nxt;
    end
  end

endmodule

/* src/dsam_fifo.sv */
// Short transaction queue between front end and mixing back end.
// Depends on dsam_pkg for the entry type.
module dsam_fifo #(
  parameter int DEPTH = dsam_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dsam_pkg::q_wr_t q_wr,
  output logic            q_full,
  input  logic            q_pop,
  output dsam_pkg::q_rd_t q_rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsam_pkg::item_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign do_push  = q_wr.push && !q_full;
  assign do_pop   = q_pop && (count_r != '0);
  assign q_rd.vld  = (count_r != '0);
  assign q_rd.item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/dsam_back.sv */
// Back end: flow-weighted products, shared radix-4 divider, result register.
// Depends on dsam_pkg; pops transactions from dsam_fifo.
module dsam_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dsam_pkg::q_rd_t                     q_rd,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dsam_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int QUO_W    = 18;
  localparam int DIV_ITER = QUO_W / 2;
  localparam int CNT_W    = $clog2(DIV_ITER);
  localparam int MAG_W    = 34;
  localparam int DEN_W    = dsam_pkg::POS_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIVT = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                  st_r, st_nxt;
  dsam_pkg::item_t             item_r, item_nxt;
  logic signed [32:0]          p_to_r, p_to_nxt, p_tr_r, p_tr_nxt;
  logic [31:0]                 p_wo_r, p_wo_nxt, p_wr_r, p_wr_nxt;
  logic                        tneg_r, tneg_nxt;
  logic [32:0]                 wn_r, wn_nxt;
  logic [DEN_W-1:0]            den_r, den_nxt;
  logic [DEN_W-1:0]            rem_r, rem_nxt;
  logic [QUO_W-1:0]            dq_r, dq_nxt;
  logic [QUO_W-1:0]            qt_r, qt_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [dsam_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic signed [MAG_W-1:0]     tn;
  logic [MAG_W-1:0]            tmag, wmag;
  logic [DEN_W-1:0]            den_raw;
  logic [DEN_W:0]              r1, r2;
  logic [DEN_W-1:0]            r1s, r2s;
  logic                        ge1, ge2, last_step, out_free;
  logic [QUO_W-1:0]            qt_signed;
  logic [dsam_pkg::POS_W-1:0]  ra_cmd;

  assign out_free   = !out_vld_r || out_tready;
  assign q_pop      = (st_r == ST_IDLE) && q_rd.vld;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign last_step  = (cnt_r == CNT_W'(DIV_ITER - 1));

  always_comb begin
    tn      = {p_to_r[32], p_to_r} + {p_tr_r[32], p_tr_r};
    tmag    = tn[MAG_W-1] ? MAG_W'(-tn) : MAG_W'(tn);
    wmag    = {1'b0, wn_r};
    den_raw = {1'b0, item_r.oa_act} + {1'b0, item_r.ra_act};

    r1  = {rem_r, dq_r[QUO_W-1]};
    ge1 = (r1 >= {1'b0, den_r});
    r1s = ge1 ? DEN_W'(r1 - {1'b0, den_r}) : r1[DEN_W-1:0];
    r2  = {r1s, dq_r[QUO_W-2]};
    ge2 = (r2 >= {1'b0, den_r});
    r2s = ge2 ? DEN_W'(r2 - {1'b0, den_r}) : r2[DEN_W-1:0];

    qt_signed = tneg_r ? QUO_W'(-qt_r) : qt_r;
    ra_cmd    = dsam_pkg::ONE - item_r.oa_cmd;
  end

  always_comb begin
    st_nxt       = st_r;
    item_nxt     = item_r;
    p_to_nxt     = p_to_r;
    p_tr_nxt     = p_tr_r;
    p_wo_nxt     = p_wo_r;
    p_wr_nxt     = p_wr_r;
    tneg_nxt     = tneg_r;
    wn_nxt       = wn_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    dq_nxt       = dq_r;
    qt_nxt       = qt_r;
    cnt_nxt      = cnt_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    case (st_r)
      ST_IDLE: begin
        if (q_rd.vld) begin
          item_nxt = q_rd.item;
          st_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        p_to_nxt = item_r.t_out * $signed({1'b0, item_r.oa_act});
        p_tr_nxt = item_r.t_ret * $signed({1'b0, item_r.ra_act});
        p_wo_nxt = item_r.w_out * item_r.oa_act;
        p_wr_nxt = item_r.w_ret * item_r.ra_act;
        st_nxt   = ST_SUM;
      end
      ST_SUM: begin
        wn_nxt   = {1'b0, p_wo_r} + {1'b0, p_wr_r};
        den_nxt  = (den_raw < {1'b0, dsam_pkg::ONE}) ? {1'b0, dsam_pkg::ONE} : den_raw;
        tneg_nxt = tn[MAG_W-1];
        rem_nxt  = DEN_W'(tmag[MAG_W-1:QUO_W]);
        dq_nxt   = tmag[QUO_W-1:0];
        cnt_nxt  = '0;
        st_nxt   = ST_DIVT;
      end
      ST_DIVT: begin
        rem_nxt = r2s;
        dq_nxt  = {dq_r[QUO_W-3:0], ge1, ge2};
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          qt_nxt  = {dq_r[QUO_W-3:0], ge1, ge2};
          rem_nxt = DEN_W'(wmag[MAG_W-1:QUO_W]);
          dq_nxt  = wmag[QUO_W-1:0];
          cnt_nxt = '0;
          st_nxt  = ST_DIVW;
        end
      end
      ST_DIVW: begin
        rem_nxt = r2s;
        dq_nxt  = {dq_r[QUO_W-3:0], ge1, ge2};
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {item_r.pos, item_r.ra_act, item_r.oa_act, ra_cmd,
                          item_r.oa_cmd, dq_r[15:0], qt_signed[15:0]};
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    p_to_r     <= p_to_nxt;
    p_tr_r     <= p_tr_nxt;
    p_wo_r     <= p_wo_nxt;
    p_wr_r     <= p_wr_nxt;
    tneg_r     <= tneg_nxt;
    wn_r       <= wn_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    qt_r       <= qt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIVT || st_r == ST_DIVW) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIVT || st_r == ST_DIVW) |-> (den_r >= {1'b0, dsam_pkg::ONE}))
    else $error("divisor below one");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && out_free) |=> (out_vld_r && st_r == ST_IDLE))
    else $error("result not registered on completion");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_MUL))
    else $error("popped transaction not started");
`endif

endmodule

/* src/damper_slew_air_mixer.sv */
// Damper slew air mixer: an accepted transaction goes through the queue, then the
// back-end states IDLE, MUL, SUM, DIVT, DIVW and FIN into the output register. The
// shared radix-4 divider forms two 18-bit quotients at 2 bits per cycle, and the back
// end takes one transaction at a time; the input queue takes more while it is busy.
// Reset (rst_n low, synchronous) restores register defaults, zeroes the actuator
// position and empties queue and output register.
module damper_slew_air_mixer #(
  parameter int QUEUE_DEPTH = dsam_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsam_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // control_signal, outside_temp, outside_humidity, return_temp, return_humidity
  input  logic [dsam_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // mixed_temp, mixed_humidity, outside_cmd_open, return_cmd_open,
  // outside_actual_open, return_actual_open, actuator_position
  output logic [dsam_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  dsam_pkg::q_wr_t q_wr;
  dsam_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            q_pop;

  dsam_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  dsam_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  dsam_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
